// ===== design/dry_wet_crossfader_macros.svh =====
// ----------------------------------------------------------------------------
// Dry/wet crossfader assertion macros
// Shared concurrent assertion shorthands, clocked on clk, reset on rst_n.
// ----------------------------------------------------------------------------
`ifndef DRY_WET_CROSSFADER_MACROS_SVH
`define DRY_WET_CROSSFADER_MACROS_SVH

// Plain property, disabled during reset
`define DWC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication, disabled during reset
`define DWC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== design/dwc_pkg.sv =====
// ----------------------------------------------------------------------------
// Dry/wet crossfader package
// Frame and mix payload types, gain format and delay ring constants.
// ----------------------------------------------------------------------------
package dwc_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int CHANNELS      = 2;
    localparam int RING_BITS     = CHANNELS * SAMPLE_BITS;
    localparam int DELAY_DEPTH   = 1024;
    localparam int ADDR_BITS     = $clog2(DELAY_DEPTH);
    localparam int GAIN_BITS     = 17;
    localparam int GAIN_FRAC     = 16;
    localparam int CFG_DATA_BITS = 17;
    localparam int PROD_BITS     = SAMPLE_BITS + 1 + GAIN_BITS + 1;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE  = GAIN_BITS'(1 << GAIN_FRAC);
    localparam logic [GAIN_BITS-1:0] GAIN_ZERO = '0;
    localparam logic [GAIN_BITS-1:0] FADE_STEP_RESET = GAIN_BITS'(64);

    // configuration register indexes
    localparam logic CFG_FADE_STEP = 1'b0;
    localparam logic CFG_DRY_DELAY = 1'b1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] dry_left;
        logic signed [SAMPLE_BITS-1:0] dry_right;
        logic signed [SAMPLE_BITS-1:0] wet_left;
        logic signed [SAMPLE_BITS-1:0] wet_right;
        logic                          wet_select;
    } frame_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mixed_left;
        logic signed [SAMPLE_BITS-1:0] mixed_right;
        logic                          is_dry;
    } mix_t;

    typedef struct packed {
        logic [GAIN_BITS-1:0] gain;
        logic                 is_dry;
    } gain_info_t;

    typedef struct packed {
        logic forward;  // delay of zero: use the dry pair of this frame
        logic written;  // ring entry read has been written since reset
    } ring_ctrl_t;

endpackage

// ===== design/dwc_ring_ram.sv =====
// ----------------------------------------------------------------------------
// Dry delay ring memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module dwc_ring_ram
    import dwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [RING_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [RING_BITS-1:0] rdata
);

    logic [RING_BITS-1:0] mem [DELAY_DEPTH];
    logic [RING_BITS-1:0] rdata_reg;

    // write dry pair
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read delayed pair, hold when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dwc_gain_ctrl.sv =====
// ----------------------------------------------------------------------------
// Crossfade gain stepper
// Moves the Q1.16 gain one fade step toward the target on each transfer.
// ----------------------------------------------------------------------------
module dwc_gain_ctrl
    import dwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  logic                 wet_select,
    input  logic [GAIN_BITS-1:0] fade_step,
    output gain_info_t           info
);

    logic [GAIN_BITS-1:0] gain_reg;
    logic [GAIN_BITS-1:0] gain_next;
    logic [GAIN_BITS-1:0] room;

    // step toward target, clamp when the step would pass it
    always_comb
    begin
        if (wet_select)
        begin
            room      = GAIN_ONE - gain_reg;
            gain_next = (room < fade_step) ? GAIN_ONE : gain_reg + fade_step;
        end
        else
        begin
            room      = gain_reg;
            gain_next = (room < fade_step) ? GAIN_ZERO : gain_reg - fade_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_ZERO;
        end
        else if (advance)
        begin
            gain_reg <= gain_next;
        end
    end

    assign info.gain   = gain_next;
    assign info.is_dry = !wet_select && (gain_next == GAIN_ZERO);

endmodule

// ===== design/dwc_mix_pipe.sv =====
// ----------------------------------------------------------------------------
// Crossfade mix pipeline
// Ring read stage, multiply stage and output register with stall handling.
// ----------------------------------------------------------------------------
module dwc_mix_pipe
    import dwc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  frame_t               frame,
    input  gain_info_t           gain_info,
    input  ring_ctrl_t           ring_ctrl,
    input  logic [RING_BITS-1:0] ring_rdata,
    output logic                 s1_free,
    output logic                 mix_valid,
    input  logic                 mix_stall,
    output mix_t                 mix
);

    // stage 1: ring read in flight
    logic                          s1_valid_reg;
    logic signed [SAMPLE_BITS-1:0] s1_wet_l_reg, s1_wet_r_reg;
    logic signed [SAMPLE_BITS-1:0] s1_fwd_l_reg, s1_fwd_r_reg;
    gain_info_t                    s1_gain_reg;
    ring_ctrl_t                    s1_ctrl_reg;

    // stage 2: products
    logic                          s2_valid_reg;
    logic signed [PROD_BITS-1:0]   s2_prod_l_reg, s2_prod_r_reg;
    logic signed [SAMPLE_BITS-1:0] s2_dry_l_reg, s2_dry_r_reg;
    logic                          s2_is_dry_reg;

    // output register
    logic out_valid_reg;
    mix_t out_mix_reg;

    logic out_free, s2_free, s1_adv, s2_adv;
    logic signed [SAMPLE_BITS-1:0] dly_l, dly_r;
    logic signed [SAMPLE_BITS:0]   diff_l, diff_r;
    logic signed [GAIN_BITS:0]     gain_s;
    logic signed [PROD_BITS-1:0]   rnd_l, rnd_r;

    // advance when the next stage is empty or moving
    assign out_free = !out_valid_reg || !mix_stall;
    assign s2_adv   = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_adv   = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;

    // select delayed dry: same-frame forward, ring data, or cleared history
    always_comb
    begin
        if (s1_ctrl_reg.forward)
        begin
            dly_l = s1_fwd_l_reg;
            dly_r = s1_fwd_r_reg;
        end
        else if (s1_ctrl_reg.written)
        begin
            dly_l = ring_rdata[SAMPLE_BITS-1:0];
            dly_r = ring_rdata[RING_BITS-1:SAMPLE_BITS];
        end
        else
        begin
            dly_l = '0;
            dly_r = '0;
        end
    end

    assign diff_l = {s1_wet_l_reg[SAMPLE_BITS-1], s1_wet_l_reg} - {dly_l[SAMPLE_BITS-1], dly_l};
    assign diff_r = {s1_wet_r_reg[SAMPLE_BITS-1], s1_wet_r_reg} - {dly_r[SAMPLE_BITS-1], dly_r};
    assign gain_s = $signed({1'b0, s1_gain_reg.gain});

    // round to nearest, ties upward
    assign rnd_l = s2_prod_l_reg + $signed(PROD_BITS'(1 << (GAIN_FRAC - 1)));
    assign rnd_r = s2_prod_r_reg + $signed(PROD_BITS'(1 << (GAIN_FRAC - 1)));

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_free)
            begin
                s2_valid_reg <= s1_adv;
            end
            if (out_free)
            begin
                out_valid_reg <= s2_adv;
            end
        end
    end

    // capture frame alongside the ring read
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_wet_l_reg <= frame.wet_left;
            s1_wet_r_reg <= frame.wet_right;
            s1_fwd_l_reg <= frame.dry_left;
            s1_fwd_r_reg <= frame.dry_right;
            s1_gain_reg  <= gain_info;
            s1_ctrl_reg  <= ring_ctrl;
        end
    end

    // multiply difference by gain
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_prod_l_reg <= diff_l * gain_s;
            s2_prod_r_reg <= diff_r * gain_s;
            s2_dry_l_reg  <= dly_l;
            s2_dry_r_reg  <= dly_r;
            s2_is_dry_reg <= s1_gain_reg.is_dry;
        end
    end

    // add scaled difference back onto delayed dry
    always_ff @(posedge clk)
    begin
        if (s2_adv)
        begin
            out_mix_reg.mixed_left  <= s2_dry_l_reg +
                rnd_l[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];
            out_mix_reg.mixed_right <= s2_dry_r_reg +
                rnd_r[GAIN_FRAC+SAMPLE_BITS-1:GAIN_FRAC];
            out_mix_reg.is_dry      <= s2_is_dry_reg;
        end
    end

    assign mix_valid = out_valid_reg;
    assign mix       = out_mix_reg;

endmodule

// ===== design/dry_wet_crossfader.sv =====
// ----------------------------------------------------------------------------
// Dry/wet crossfader with latency compensation
// Delays the dry pair through a ring and crossfades it against the wet pair.
// ----------------------------------------------------------------------------
// Usage:
//   frame / frame_valid / frame_stall carry one stereo frame per transfer:
//   dry pair, wet pair and the wet_select fade target.
//   mix / mix_valid / mix_stall return one mixed frame per input frame,
//   in order, with is_dry set once the target is dry and the gain is zero.
//   cfg_we / cfg_index / cfg_data write fade_step (index 0) and dry_delay
//   (index 1); write them only while no frame is in flight.
//   An input transfer passes the stage for the delay ring read port, the
//   stage for the gain multiply and the output register before the
//   earliest mix transfer. Throughput is one frame per cycle while the
//   output is not stalled, set by the single ring read/write port pair.
//   Reset clears the gain to fully dry, the ring write pointer to zero and
//   loads fade_step 64, dry_delay 0. Ring history reads as zero until its
//   entry is first written, tracked by a wrap flag, so no clearing pass.
//   When the receiver stalls, the output holds and the three stages fill;
//   frame_stall rises only when all of them hold a frame.
// ----------------------------------------------------------------------------
module dry_wet_crossfader
    import dwc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic                     cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    input  logic                     frame_valid,
    output logic                     frame_stall,
    input  frame_t                   frame,
    output logic                     mix_valid,
    input  logic                     mix_stall,
    output mix_t                     mix
);

    logic [GAIN_BITS-1:0] fade_step_reg;
    logic [ADDR_BITS-1:0] dry_delay_reg;
    logic [ADDR_BITS-1:0] slot_reg;
    logic                 wrapped_reg;

    logic                 accept;
    logic                 s1_free;
    logic [ADDR_BITS-1:0] rd_addr;
    logic [RING_BITS-1:0] ring_rdata;
    gain_info_t           gain_info;
    ring_ctrl_t           ring_ctrl;

    assign accept      = frame_valid && s1_free;
    assign frame_stall = !s1_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_step_reg <= FADE_STEP_RESET;
            dry_delay_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FADE_STEP: fade_step_reg <= cfg_data[GAIN_BITS-1:0];
                CFG_DRY_DELAY: dry_delay_reg <= cfg_data[ADDR_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // advance write slot, note first wrap of the ring
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg    <= '0;
            wrapped_reg <= 1'b0;
        end
        else if (accept)
        begin
            slot_reg <= slot_reg + ADDR_BITS'(1);
            if (slot_reg == ADDR_BITS'(DELAY_DEPTH - 1))
            begin
                wrapped_reg <= 1'b1;
            end
        end
    end

    // read address trails the write slot by the dry delay
    assign rd_addr           = slot_reg - dry_delay_reg;
    assign ring_ctrl.forward = (dry_delay_reg == '0);
    assign ring_ctrl.written = wrapped_reg || (rd_addr < slot_reg);

    dwc_ring_ram u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (slot_reg),
        .wdata ({frame.dry_right, frame.dry_left}),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (ring_rdata)
    );

    dwc_gain_ctrl u_gain (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (accept),
        .wet_select (frame.wet_select),
        .fade_step  (fade_step_reg),
        .info       (gain_info)
    );

    dwc_mix_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame      (frame),
        .gain_info  (gain_info),
        .ring_ctrl  (ring_ctrl),
        .ring_rdata (ring_rdata),
        .s1_free    (s1_free),
        .mix_valid  (mix_valid),
        .mix_stall  (mix_stall),
        .mix        (mix)
    );

endmodule

// ===== design/dwc_checker.sv =====
// ----------------------------------------------------------------------------
// Dry/wet crossfader port checker
// Watches the frame and mix channels of the top level over time.
// ----------------------------------------------------------------------------
`include "dry_wet_crossfader_macros.svh"

module dwc_checker
    import dwc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic frame_valid,
    input logic frame_stall,
    input logic mix_valid,
    input logic mix_stall,
    input mix_t mix
);

    // hold a stalled mix transfer
    `DWC_ASSERT(a_mix_valid_hold, (mix_valid && mix_stall) |=> mix_valid, "mix_valid dropped while stalled")
    `DWC_ASSERT(a_mix_data_hold, (mix_valid && mix_stall) |=> $stable(mix), "mix changed while stalled")

    // input backpressure only when the output itself is blocked
    `DWC_ASSERT_IMP(a_stall_cause, frame_stall, mix_valid && mix_stall, "frame stalled with output free")

    // an output transfer with no input frees the first stage
    `DWC_ASSERT(a_drain_frees, (mix_valid && !mix_stall && !frame_valid) |=> !frame_stall, "frame stall after drain")

endmodule

bind dry_wet_crossfader dwc_checker u_dwc_checker (.*);

// ===== verif/dry_wet_crossfader_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dry/wet crossfader testbench
// Streams stereo frames through the crossfader with random gaps and output
// stalls, predicts every mixed frame from a local copy of the delay ring and
// gain, and compares each output transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module dry_wet_crossfader_tb;
    import dwc_pkg::*;

    localparam int PIPE_LATENCY = 3;
    localparam int LONG_HOLD    = 300;
    localparam int MAX_PRINTS   = 40;

    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic                     cfg_index = CFG_FADE_STEP;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic                     frame_valid = 1'b0;
    logic                     frame_stall;
    frame_t                   frame = '0;
    logic                     mix_valid;
    logic                     mix_stall = 1'b0;
    mix_t                     mix;

    // local copy of the crossfader state
    bit signed [SAMPLE_BITS-1:0] ring_left  [DELAY_DEPTH];
    bit signed [SAMPLE_BITS-1:0] ring_right [DELAY_DEPTH];
    bit [ADDR_BITS-1:0]          ring_wr = '0;
    bit [GAIN_BITS-1:0]          gain_level = '0;
    int unsigned                 fade_step_cfg = FADE_STEP_RESET;
    int unsigned                 dry_delay_cfg = 0;

    mix_t pending_mix[$];
    mix_t want_mix;
    int   error_count = 0;
    bit   sender_idle = 1'b1;
    bit   receiver_idle = 1'b1;
    bit   long_hold_req = 1'b0;

    dry_wet_crossfader u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame       (frame),
        .mix_valid   (mix_valid),
        .mix_stall   (mix_stall),
        .mix         (mix)
    );

    always #5 clk = ~clk;

    // Step the gain toward its target and clamp there
    function automatic bit [GAIN_BITS-1:0] next_gain(input bit [GAIN_BITS-1:0] g,
                                                     input bit [GAIN_BITS-1:0] target);
        longint s;
        longint gi;
        longint ti;
        s  = fade_step_cfg;
        gi = g;
        ti = target;
        if (ti > gi)
            return GAIN_BITS'((ti - gi < s) ? ti : gi + s);
        return GAIN_BITS'((gi - ti < s) ? ti : gi - s);
    endfunction

    // delayed dry plus the gained difference, rounded to nearest, ties upward
    function automatic logic signed [SAMPLE_BITS-1:0] blend(
        input logic signed [SAMPLE_BITS-1:0] dry,
        input logic signed [SAMPLE_BITS-1:0] wet);
        longint d;
        longint w;
        longint t;
        d = dry;
        w = wet;
        t = (w - d) * longint'(gain_level) + 32768;
        return SAMPLE_BITS'(d + (t >>> GAIN_FRAC));
    endfunction

    // Advance the local state by one frame and return the mixed frame it yields
    function automatic mix_t mix_frame(input frame_t f);
        mix_t               m;
        bit [ADDR_BITS-1:0] rd;
        bit [GAIN_BITS-1:0] target;
        target = f.wet_select ? GAIN_ONE : GAIN_ZERO;
        ring_left[ring_wr]  = f.dry_left;
        ring_right[ring_wr] = f.dry_right;
        rd = ring_wr - ADDR_BITS'(dry_delay_cfg);
        ring_wr = ring_wr + ADDR_BITS'(1);
        gain_level = next_gain(gain_level, target);
        m.mixed_left  = blend(ring_left[rd], f.wet_left);
        m.mixed_right = blend(ring_right[rd], f.wet_right);
        m.is_dry      = !f.wet_select && (gain_level == GAIN_ZERO);
        return m;
    endfunction

    task automatic report_mismatch(input string field, input longint got, input longint want);
        if (error_count < MAX_PRINTS)
            $display("%0t ns: mismatch on %s: got %0d, want %0d", $time, field, got, want);
        error_count++;
    endtask

    // Record accepted frames and check each output transfer against the oldest prediction
    always @(posedge clk) begin
        if (rst_n && frame_valid && !frame_stall)
            pending_mix.push_back(mix_frame(frame));
        if (rst_n && mix_valid && !mix_stall) begin
            if (pending_mix.size() == 0) begin
                report_mismatch("unexpected mixed frame", mix.mixed_left, 0);
            end
            else begin
                want_mix = pending_mix.pop_front();
                if (mix.mixed_left !== want_mix.mixed_left)
                    report_mismatch("mixed_left", mix.mixed_left, want_mix.mixed_left);
                if (mix.mixed_right !== want_mix.mixed_right)
                    report_mismatch("mixed_right", mix.mixed_right, want_mix.mixed_right);
                if (mix.is_dry !== want_mix.is_dry)
                    report_mismatch("is_dry", mix.is_dry, want_mix.is_dry);
            end
        end
    end

    // Output side: random stalls per transfer, plus one long hold on request
    initial begin
        int n;
        int hold_count;
        forever begin
            if (long_hold_req) begin
                mix_stall <= 1'b1;
                hold_count = 0;
                while (hold_count < LONG_HOLD) begin
                    @(posedge clk);
                    hold_count++;
                end
                long_hold_req = 1'b0;
            end
            else begin
                n = receiver_idle ? $urandom_range(0, 17) : 0;
                if (n > 0) begin
                    mix_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
            end
            mix_stall <= 1'b0;
            do @(posedge clk); while (!mix_valid && !long_hold_req);
        end
    end

    // Offer one frame after a random gap and hold it until the transfer
    task automatic send_frame(input frame_t f);
        int gap;
        gap = sender_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            frame_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_valid <= 1'b1;
        frame       <= f;
        do @(posedge clk); while (frame_stall);
    endtask

    // Drop valid and wait until every predicted frame has come out
    task automatic wait_idle();
        frame_valid <= 1'b0;
        @(posedge clk);
        while (pending_mix.size() != 0) @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    // One register write, then a quiet wait with the enable driven low again
    task automatic write_reg(input logic idx, input int unsigned value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_FADE_STEP)
            fade_step_cfg = value & 32'h1FFFF;
        else
            dry_delay_cfg = value & 32'h3FF;
        @(posedge clk);
    endtask

    function automatic frame_t make_frame(input logic signed [SAMPLE_BITS-1:0] dl,
                                          input logic signed [SAMPLE_BITS-1:0] dr,
                                          input logic signed [SAMPLE_BITS-1:0] wl,
                                          input logic signed [SAMPLE_BITS-1:0] wr,
                                          input logic sel);
        frame_t f;
        f.dry_left   = dl;
        f.dry_right  = dr;
        f.wet_left   = wl;
        f.wet_right  = wr;
        f.wet_select = sel;
        return f;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // mostly fast fades so the gain reaches both ends within a run
    function automatic int unsigned pick_fade_step();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 1;
            2:       return 65536;
            3:       return 131071;
            4:       return $urandom_range(1, 65536);
            5:       return $urandom_range(65537, 131071);
            default: return $urandom_range(512, 16384);
        endcase
    endfunction

    function automatic int unsigned pick_delay();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 1023;
            2:       return $urandom_range(0, 8);
            default: return $urandom_range(0, 1023);
        endcase
    endfunction

    // Target dry from reset: output is the undelayed dry pair
    task automatic test_dry_passthrough();
        send_frame(make_frame(S_MAX, S_MIN, S_MIN, S_MAX, 1'b0));
        send_frame(make_frame(S_MIN, S_MAX, S_MAX, S_MIN, 1'b0));
        send_frame(make_frame('0, '1, S_MAX, '0, 1'b0));
        send_frame(make_frame('1, '0, '0, S_MIN, 1'b0));
    endtask

    // Reset fade step moves the gain a little each frame
    task automatic test_small_fade();
        send_frame(make_frame(S_MIN, S_MAX, S_MAX, S_MIN, 1'b1));
        send_frame(make_frame(S_MIN, S_MAX, S_MAX, S_MIN, 1'b1));
        send_frame(make_frame(S_MAX, S_MIN, S_MIN, S_MAX, 1'b0));
    endtask

    // Step above range: gain jumps straight to the target, fully wet is exact
    task automatic test_step_above_range();
        wait_idle();
        write_reg(CFG_FADE_STEP, 131071);
        send_frame(make_frame(S_MIN, S_MAX, S_MAX, S_MIN, 1'b1));
        send_frame(make_frame(S_MAX, S_MIN, S_MIN, S_MAX, 1'b1));
        send_frame(make_frame(S_MAX, S_MIN, S_MIN, S_MAX, 1'b0));
    endtask

    // Half gain on odd differences lands on rounding ties of both signs
    task automatic test_rounding_ties();
        wait_idle();
        write_reg(CFG_FADE_STEP, 32768);
        send_frame(make_frame(24'sd100, -24'sd100, 24'sd101, -24'sd99, 1'b1));
        send_frame(make_frame(24'sd5, 24'sd5, 24'sd5, 24'sd5, 1'b0));
        send_frame(make_frame(24'sd100, -24'sd100, 24'sd99, -24'sd101, 1'b1));
        send_frame(make_frame(24'sd7, 24'sd7, -24'sd7, 24'sd7, 1'b1));
        send_frame(make_frame(24'sd10, 24'sd10, 24'sd13, 24'sd7, 1'b0));
    endtask

    // Zero step freezes the gain at half whatever the target
    task automatic test_zero_step();
        wait_idle();
        write_reg(CFG_FADE_STEP, 0);
        send_frame(make_frame(24'sd1000, S_MIN, S_MAX, 24'sd3, 1'b0));
        send_frame(make_frame(S_MAX, 24'sd1, S_MIN, 24'sd2, 1'b1));
        send_frame(make_frame(S_MIN, S_MAX, S_MAX, S_MIN, 1'b0));
    endtask

    // Longest delay reads far back into the ring, then the shortest nonzero one
    task automatic test_dry_delay_ends();
        wait_idle();
        write_reg(CFG_FADE_STEP, 65536);
        write_reg(CFG_DRY_DELAY, 1023);
        send_frame(make_frame(S_MAX, S_MAX, S_MIN, S_MIN, 1'b0));
        send_frame(make_frame(S_MIN, S_MIN, S_MAX, S_MAX, 1'b0));
        send_frame(make_frame(24'sd9, 24'sd9, 24'sd9, 24'sd9, 1'b0));
        wait_idle();
        write_reg(CFG_DRY_DELAY, 1);
        send_frame(make_frame(S_MAX, '1, '0, S_MIN, 1'b0));
        send_frame(make_frame('1, S_MAX, S_MIN, '0, 1'b0));
    endtask

    // Hold the output off for a long stretch while frames keep coming
    task automatic test_output_backpressure();
        wait_idle();
        sender_idle   = 1'b0;
        long_hold_req = 1'b1;
        repeat (40)
            send_frame(make_frame(pick_sample(), pick_sample(), pick_sample(),
                                  pick_sample(), 1'($urandom())));
        sender_idle = 1'b1;
    endtask

    // Phases of random settings, each a series of constant-target runs
    task automatic test_random_fades(input int total);
        int sent;
        int phase_len;
        int run_len;
        bit target;
        sent = 0;
        while (sent < total) begin
            wait_idle();
            write_reg(CFG_FADE_STEP, pick_fade_step());
            write_reg(CFG_DRY_DELAY, pick_delay());
            sender_idle   = $urandom_range(0, 3) != 0;
            receiver_idle = $urandom_range(0, 3) != 0;
            phase_len = $urandom_range(100, 200);
            while (phase_len > 0 && sent < total) begin
                // an occasional single-frame run toggles the target erratically
                run_len = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 60);
                target  = 1'($urandom());
                repeat (run_len) begin
                    send_frame(make_frame(pick_sample(), pick_sample(), pick_sample(),
                                          pick_sample(), target));
                    sent++;
                    phase_len--;
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_dry_passthrough();
        test_small_fade();
        test_step_above_range();
        test_rounding_ties();
        test_zero_step();
        test_dry_delay_ends();
        test_output_backpressure();
        test_random_fades(1290);
        wait_idle();
        repeat (10) @(posedge clk);
        if (error_count == 0 && pending_mix.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Stop a hung run
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
